// File: hdl/rom_ram_bank_mapper_defines.svh
// Assertion macros shared by the bank mapper RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ROM_RAM_BANK_MAPPER_DEFINES_SVH
`define ROM_RAM_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RRBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rom_ram_bank_mapper: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define RRBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rom_ram_bank_mapper: next-cycle check failed");

`endif

// File: hdl/rrbm_pkg.sv
// Types, constants and helper functions of the ROM/RAM bank mapper.
// Depends on nothing; imported by rom_ram_bank_mapper.
`default_nettype none

package rrbm_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
  localparam int ROM_BANK_W     = 7;
  localparam int ROM_ADDR_W     = 21;
  localparam int CODE_W         = 3;

  // result kind, carried on m_tuser
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_t;

  // configuration register indexes
  localparam logic REG_ROM_SIZE = 1'b0;
  localparam logic REG_RAM_SIZE = 1'b1;

  // 8 KiB bus regions, decoded from address[15:13]
  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_HIGH     = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_CART_RAM = 3'd5;

  // 16 KiB ROM windows, decoded from address[15:14]
  localparam logic [1:0] WIN_ROM_FIXED  = 2'd0;
  localparam logic [1:0] WIN_ROM_BANKED = 2'd1;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  // RAM bank count from the header size code
  function automatic logic [4:0] ram_bank_count(input logic [CODE_W-1:0] code);
    logic [4:0] n;
    case (code)
      3'd2:    n = 5'd1;
      3'd3:    n = 5'd4;
      3'd4:    n = 5'd16;
      3'd5:    n = 5'd8;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rom_ram_bank_mapper.sv
// Cartridge ROM/RAM bank mapper: one bus access in, one result word out.
// Result: registered, valid in the cycle after the input word is accepted.
// Throughput: one word per cycle; the result register refills in the cycle
// it is drained, so the input stalls only while the receiver holds off or the clearing sweep runs.
// Reset: control registers clear at once; the cart RAM is then zeroed by a
// sweep over all MAX_RAM_BANKS * 8192 entries (32768 by default) during which no
// input word is taken. Configuration writes are accepted throughout.
`default_nettype none

module rom_ram_bank_mapper #(
  parameter int MAX_ROM_BANKS = 128,
  parameter int MAX_RAM_BANKS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [2:0]  cfg_wdata,
  // access stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
  input  wire logic        s_tuser,   // [0] req_type (0 read, 1 write)
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [20:0] rom_address, [28:21] read_data, zero above
  output logic [1:0]       m_tuser    // [1:0] target
);

  import rrbm_pkg::*;

  `include "rom_ram_bank_mapper_defines.svh"

  localparam int RAM_DEPTH = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_DEPTH - 1);

  // ---------------------------------------------------------------------
  // Configuration and mapper control registers
  // ---------------------------------------------------------------------
  logic [CODE_W-1:0] rom_size_code;
  logic [CODE_W-1:0] ram_size_code;
  logic              ram_enable;
  logic [4:0]        rom_bank_low;
  logic [1:0]        bank_high;
  logic              banking_mode;

  // clearing sweep
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  logic        is_write;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        accept;

  assign is_write   = s_tuser;
  assign address    = s_tdata[15:0];
  assign write_data = s_tdata[23:16];
  assign accept     = s_tvalid && s_tready;

  // hold the input while the sweep runs or a finished word is not taken
  assign s_tready = !clearing && (!m_tvalid || m_tready);

  // ROM bank mask: bank count is 2 << code, capped at MAX_ROM_BANKS
  logic [8:0]            rom_count;
  logic [8:0]            rom_cap;
  logic [8:0]            rom_cap_m1;
  logic [ROM_BANK_W-1:0] rom_mask;

  assign rom_count  = 9'd2 << rom_size_code;
  assign rom_cap    = (rom_count > 9'(MAX_ROM_BANKS)) ? 9'(MAX_ROM_BANKS) : rom_count;
  assign rom_cap_m1 = rom_cap - 9'd1;
  assign rom_mask   = rom_cap_m1[ROM_BANK_W-1:0];

  // RAM bank mask and presence
  logic [4:0] ram_count;
  logic [4:0] ram_cap;
  logic [4:0] ram_cap_m1;
  logic       ram_ok;

  assign ram_count  = ram_bank_count(ram_size_code);
  assign ram_cap    = (ram_count > 5'(MAX_RAM_BANKS)) ? 5'(MAX_RAM_BANKS) : ram_count;
  assign ram_cap_m1 = ram_cap - 5'd1;
  assign ram_ok     = ram_enable && (ram_cap != 5'd0);

  // Bank numbers. A masked RAM bank always stays below MAX_RAM_BANKS, so
  // the byte index needs no wrap.
  logic [4:0]            low_eff;
  logic [ROM_BANK_W-1:0] bank_fixed;
  logic [ROM_BANK_W-1:0] bank_switched;
  logic [1:0]            ram_bank;
  logic [RAM_AW-1:0]     ram_idx;

  assign low_eff       = (rom_bank_low == 5'd0) ? 5'd1 : rom_bank_low;
  assign bank_fixed    = banking_mode ? ({bank_high, 5'd0} & rom_mask) : '0;
  assign bank_switched = {bank_high, low_eff} & rom_mask;
  assign ram_bank      = (banking_mode ? bank_high : 2'd0) & ram_cap_m1[1:0];
  assign ram_idx       = RAM_AW'({ram_bank, address[RAM_OFS_W-1:0]});

  logic in_ram_win;
  logic ram_wr;
  logic ram_rd;

  assign in_ram_win = (address[15:13] == RGN_CART_RAM) && ram_ok;
  assign ram_wr     = accept && is_write && in_ram_win;
  assign ram_rd     = accept && !is_write && in_ram_win;

  // result of this access, before the RAM data joins it
  target_t               tgt_next;
  logic [ROM_ADDR_W-1:0] rom_addr_next;
  logic [7:0]            rdata_next;

  always_comb begin
    tgt_next      = TGT_NONE;
    rom_addr_next = '0;
    rdata_next    = 8'd0;
    if (!is_write) begin
      if (address[15:14] == WIN_ROM_FIXED) begin
        tgt_next      = TGT_ROM;
        rom_addr_next = {bank_fixed, address[ROM_OFS_W-1:0]};
      end else if (address[15:14] == WIN_ROM_BANKED) begin
        tgt_next      = TGT_ROM;
        rom_addr_next = {bank_switched, address[ROM_OFS_W-1:0]};
      end else if (in_ram_win) begin
        tgt_next      = TGT_RAM;
      end else begin
        rdata_next    = OPEN_BUS;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Control registers: a write to the low half of the map updates them at
  // the accept edge, so the very next word already sees the new banking.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code <= '0;
      ram_size_code <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROM_SIZE: rom_size_code <= cfg_wdata;
        REG_RAM_SIZE: ram_size_code <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable   <= 1'b0;
      rom_bank_low <= '0;
      bank_high    <= '0;
      banking_mode <= 1'b0;
    end else if (accept && is_write) begin
      case (address[15:13])
        RGN_RAM_EN:   ram_enable   <= (write_data[3:0] == RAM_EN_KEY);
        RGN_ROM_BANK: rom_bank_low <= write_data[4:0];
        RGN_HIGH:     bank_high    <= write_data[1:0];
        RGN_MODE:     banking_mode <= write_data[0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Clearing sweep after reset: one entry per cycle
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + RAM_AW'(1);
      if (clr_addr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Cart RAM: one write port, one registered read port. A write lands at
  // its accept edge, so a read accepted next cycle already sees it.
  // ---------------------------------------------------------------------
  logic [7:0] cart_ram [RAM_DEPTH];
  logic [7:0] ram_q;

  always_ff @(posedge clk) begin
    if (clearing) begin
      cart_ram[clr_addr] <= 8'd0;
    end else if (ram_wr) begin
      cart_ram[ram_idx] <= write_data;
    end
  end

  // read data holds while the result word stalls: no new read is issued
  always_ff @(posedge clk) begin
    if (ram_rd) begin
      ram_q <= cart_ram[ram_idx];
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  target_t               out_tgt;
  logic [ROM_ADDR_W-1:0] out_rom_addr;
  logic [7:0]            out_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tgt      <= tgt_next;
      out_rom_addr <= rom_addr_next;
      out_rdata    <= rdata_next;
    end
  end

  logic [7:0] read_data;

  assign read_data = (out_tgt == TGT_RAM) ? ram_q : out_rdata;
  assign m_tdata   = {3'd0, read_data, out_rom_addr};
  assign m_tuser   = out_tgt;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `RRBM_ASSERT_NOW(a_no_accept_in_sweep, clk, rst, clearing, !s_tready)
  `RRBM_ASSERT_NEXT(a_ram_read_result, clk, rst, ram_rd, m_tvalid && (m_tuser == TGT_RAM))
  `RRBM_ASSERT_NEXT(a_sweep_ends, clk, rst, clearing && (clr_addr == CLR_LAST), !clearing)
  `RRBM_ASSERT_NOW(a_rom_only_no_data, clk, rst, m_tvalid && (m_tuser == TGT_ROM),
                   m_tdata[28:21] == 8'd0)

endmodule

`default_nettype wire

// File: bench/rom_ram_bank_mapper_tb.sv
// Self-checking bench for the cartridge ROM/RAM bank mapper: directed and random bus accesses.
// Predicts each result word from its own model of the bank registers and cart RAM.
// Depends on rrbm_pkg and rom_ram_bank_mapper.
`default_nettype none

module rom_ram_bank_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrbm_pkg::*;

  localparam int MAX_ROM = 128;
  localparam int MAX_RAM = 4;
  localparam int RAM_BYTES = MAX_RAM * RAM_BANK_BYTES;
  // no word may take longer than this to move; the RAM clearing sweep is the longest quiet stretch
  localparam int QUIET_LIMIT = 120000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 122;
  localparam int HOLD_CYCLES = 300;

  // access kinds on s_tuser
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    target_t     target;
    logic [20:0] rom_address;
    logic [7:0]  read_data;
  } mapped_t;

  // Tracks the mapper's registers and cart RAM, and the results still owed by the block.
  class bank_map_scoreboard;
    logic [2:0] rom_code;
    logic [2:0] ram_code;
    logic       ram_on;
    logic [4:0] bank_low;
    logic [1:0] bank_high;
    logic       mode_sel;
    bit [7:0]   cart_ram_copy [RAM_BYTES];
    mapped_t    pending_results [$];
    int         errors;

    function new();
      rom_code  = '0;
      ram_code  = '0;
      ram_on    = 1'b0;
      bank_low  = '0;
      bank_high = '0;
      mode_sel  = 1'b0;
      errors    = 0;
    endfunction

    function void set_size(logic idx, logic [2:0] code);
      if (idx == REG_ROM_SIZE) begin
        rom_code = code;
      end else begin
        ram_code = code;
      end
    endfunction

    function logic [6:0] rom_mask();
      int count;
      count = 2 << rom_code;
      if (count > MAX_ROM) count = MAX_ROM;
      return 7'(count - 1);
    endfunction

    function int ram_count();
      int n;
      case (ram_code)
        3'd2:    n = 1;
        3'd3:    n = 4;
        3'd4:    n = 16;
        3'd5:    n = 8;
        default: n = 0;
      endcase
      return (n > MAX_RAM) ? MAX_RAM : n;
    endfunction

    // byte index into cart RAM for an address in the RAM window
    function logic [14:0] ram_byte(logic [15:0] addr);
      logic [1:0] bank;
      bank = (mode_sel ? bank_high : 2'd0) & 2'(ram_count() - 1);
      return {bank, addr[12:0]};
    endfunction

    function void note_access(access_t acc);
      mapped_t    want;
      logic       ram_ok;
      logic       in_ram_win;
      logic [6:0] bank;
      want.target      = TGT_NONE;
      want.rom_address = '0;
      want.read_data   = '0;
      ram_ok     = ram_on && (ram_count() > 0);
      in_ram_win = (acc.addr >= 16'hA000) && (acc.addr <= 16'hBFFF);
      if (acc.wr == ACC_WRITE) begin
        if (acc.addr <= 16'h1FFF) begin
          ram_on = (acc.data[3:0] == RAM_EN_KEY);
        end else if (acc.addr <= 16'h3FFF) begin
          bank_low = acc.data[4:0];
        end else if (acc.addr <= 16'h5FFF) begin
          bank_high = acc.data[1:0];
        end else if (acc.addr <= 16'h7FFF) begin
          mode_sel = acc.data[0];
        end else if (in_ram_win && ram_ok) begin
          cart_ram_copy[ram_byte(acc.addr)] = acc.data;
        end
      end else if (acc.addr <= 16'h3FFF) begin
        // fixed window follows the upper bank bits only in mode 1
        bank = mode_sel ? ({bank_high, 5'd0} & rom_mask()) : 7'd0;
        want.target      = TGT_ROM;
        want.rom_address = {bank, acc.addr[13:0]};
      end else if (acc.addr <= 16'h7FFF) begin
        // a low bank of zero selects bank one
        bank = {bank_high, (bank_low == 5'd0) ? 5'd1 : bank_low} & rom_mask();
        want.target      = TGT_ROM;
        want.rom_address = {bank, acc.addr[13:0]};
      end else if (in_ram_win && ram_ok) begin
        want.target    = TGT_RAM;
        want.read_data = cart_ram_copy[ram_byte(acc.addr)];
      end else begin
        want.read_data = OPEN_BUS;
      end
      pending_results.push_back(want);
    endfunction

    function void check_result(logic [1:0] kind, logic [31:0] word);
      mapped_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no access pending: tuser %0d tdata 0x%08h", kind, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.target) begin
        $error("target: expected %0d, actual %0d", want.target, kind);
        errors++;
      end
      if (word[20:0] !== want.rom_address) begin
        $error("rom_address: expected 0x%06h, actual 0x%06h", want.rom_address, word[20:0]);
        errors++;
      end
      if (word[28:21] !== want.read_data) begin
        $error("read_data: expected 0x%02h, actual 0x%02h", want.read_data, word[28:21]);
        errors++;
      end
      if (word[31:29] !== 3'd0) begin
        $error("tdata padding: expected 0, actual %0d", word[31:29]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = REG_ROM_SIZE;
  logic [2:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = ACC_READ;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  bank_map_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stall_go = 1'b0;
  bit stall_taken = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  rom_ram_bank_mapper u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] address, [23:16] write_data
    .s_tuser  (s_tuser),   // [0] req_type
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [20:0] rom_address, [28:21] read_data, zero above
    .m_tuser  (m_tuser)    // [1:0] target
  );

  always #10 clk = ~clk;

  // Note every accepted access word; values read here are those held before the edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.note_access('{s_tuser, s_tdata[15:0], s_tdata[23:16]});
    end
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tuser, m_tdata);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off so the block fills and
  // stalls its input while the sender keeps offering words.
  always @(posedge clk) begin
    if (stall_go && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left  = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up when no word moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rom_ram_bank_mapper regression: fail");
      $finish;
    end
  end

  // Offer one access word, after a random gap, and hold it until it is taken.
  task automatic send_access(input logic wr, input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = 0;
    while (($urandom_range(99) < send_idle_pct) && (gap < 20)) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= wr;
    s_tdata  <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Write both size registers on consecutive edges; the block must be idle.
  task automatic write_sizes(input logic [2:0] rom_code, input logic [2:0] ram_code);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ROM_SIZE;
    cfg_wdata <= rom_code;
    @(posedge clk);
    sb.set_size(REG_ROM_SIZE, rom_code);
    cfg_addr  <= REG_RAM_SIZE;
    cfg_wdata <= ram_code;
    @(posedge clk);
    sb.set_size(REG_RAM_SIZE, ram_code);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, let the last accepted word be noted, and wait until every predicted
  // word has come back, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed control sequences with random content: enable keys, bank and
  // mode writes, RAM traffic on a few hot offsets, ROM reads, and some raw noise.
  task automatic send_random_access();
    int          pick;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [12:0] ofs;
    pick = $urandom_range(99);
    data = 8'($urandom_range(255));
    wr   = ACC_WRITE;
    if (pick < 10) begin
      addr = 16'($urandom_range(16'h1FFF));
      if ($urandom_range(9) < 7) data[3:0] = RAM_EN_KEY;
    end else if (pick < 18) begin
      addr = 16'($urandom_range(16'h3FFF, 16'h2000));
    end else if (pick < 25) begin
      addr = 16'($urandom_range(16'h5FFF, 16'h4000));
    end else if (pick < 31) begin
      addr = 16'($urandom_range(16'h7FFF, 16'h6000));
    end else if (pick < 72) begin
      // half the RAM traffic lands on a few offsets at either end so reads hit earlier writes
      if ($urandom_range(1)) begin
        ofs = {($urandom_range(1) ? 10'h3FF : 10'h000), 3'($urandom_range(7))};
      end else begin
        ofs = 13'($urandom);
      end
      addr = 16'hA000 | {3'd0, ofs};
      wr   = (pick < 50) ? ACC_WRITE : ACC_READ;
    end else if (pick < 92) begin
      addr = 16'($urandom_range(16'h7FFF));
      wr   = ACC_READ;
    end else begin
      addr = 16'($urandom);
      wr   = $urandom_range(1) ? ACC_WRITE : ACC_READ;
    end
    send_access(wr, addr, data);
  endtask

  logic [2:0] rom_plan [PHASES] = '{3'd0, 3'd6, 3'd7, 3'd1, 3'd3, 3'd5, 3'd2, 3'd4};
  logic [2:0] ram_plan [PHASES] = '{3'd3, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6, 3'd7, 3'd1};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sizes may be written during the clearing sweep; the sender then waits on tready.
    // ROM code 7 saturates at the largest bank count; RAM code 3 gives four banks.
    write_sizes(3'd7, 3'd3);

    // Directed words: both ROM windows at their edges, RAM gated off, then on.
    send_access(ACC_READ,  16'h0000, 8'h00);
    send_access(ACC_READ,  16'h3FFF, 8'hFF);
    send_access(ACC_READ,  16'h4000, 8'h00);  // low bank zero reads as one
    send_access(ACC_READ,  16'h7FFF, 8'h00);
    send_access(ACC_READ,  16'hA000, 8'h00);  // RAM disabled: open bus
    send_access(ACC_WRITE, 16'hA000, 8'h55);  // dropped while disabled
    send_access(ACC_WRITE, 16'h0000, 8'h0A);
    send_access(ACC_READ,  16'hA000, 8'h00);
    send_access(ACC_WRITE, 16'hBFFF, 8'hFF);
    send_access(ACC_READ,  16'hBFFF, 8'h00);
    send_access(ACC_WRITE, 16'h2000, 8'hFF);
    send_access(ACC_WRITE, 16'h5FFF, 8'hFF);
    send_access(ACC_READ,  16'h4000, 8'h00);  // largest bank, masked by the count
    send_access(ACC_WRITE, 16'h7FFF, 8'h01);  // mode 1
    send_access(ACC_READ,  16'h0000, 8'h00);  // fixed window follows the upper bits
    send_access(ACC_WRITE, 16'hA000, 8'hA5);  // lands in RAM bank 3
    send_access(ACC_READ,  16'hA000, 8'h00);
    send_access(ACC_WRITE, 16'h6000, 8'hFE);  // back to mode 0
    send_access(ACC_READ,  16'hA000, 8'h00);
    send_access(ACC_WRITE, 16'h3FFF, 8'h00);
    send_access(ACC_READ,  16'h5555, 8'h00);
    send_access(ACC_READ,  16'h8000, 8'h00);  // outside every window
    send_access(ACC_READ,  16'hFFFF, 8'h00);
    send_access(ACC_WRITE, 16'hFFFF, 8'hFF);  // write that touches nothing
    send_access(ACC_WRITE, 16'h1FFF, 8'hF0);  // disable RAM again
    drain();

    // Random phases: every size setting between phases; cart RAM carries across them.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_sizes(rom_plan[ph], ram_plan[ph]);
      if (ph < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 52;
      end else if (ph < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 1) stall_go <= 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) send_random_access();
      drain();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("rom_ram_bank_mapper regression: pass");
    end else begin
      $display("rom_ram_bank_mapper regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
